// ===== hw/rtl/lmsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lmsf_pkg
// Shared types and constants of the LMS adaptive FIR filter.
// ----------------------------------------------------------------------------
package lmsf_pkg;

  // Step size format: unsigned fraction in units of 2^-24
  localparam int MU_WIDTH = 16;
  localparam int MU_FRAC  = 24;
  // Accumulator and update arithmetic wrap at this width
  localparam int ACC_W    = 64;

  // Register indexes
  localparam logic REG_ADAPT = 1'b0;
  localparam logic REG_STEP  = 1'b1;

  // Register reset values
  localparam logic                ADAPT_RESET = 1'b1;
  localparam logic [MU_WIDTH-1:0] STEP_RESET  = 16'd16777;

  // Configuration seen by the core
  typedef struct packed {
    logic                adapt;
    logic [MU_WIDTH-1:0] step;
  } cfg_t;

  // Core sequencer states
  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_FILT   = 8'b0000_0100,
    ST_FDRAIN = 8'b0000_1000,
    ST_CALC   = 8'b0001_0000,
    ST_EMIT   = 8'b0010_0000,
    ST_UPD    = 8'b0100_0000,
    ST_UDRAIN = 8'b1000_0000
  } state_t;

endpackage

// ===== hw/rtl/lms_adaptive_fir_filter.sv =====
// Operation: a coefficient write item is written in the cycle it is accepted.
//   A sample item gives its result after one filter pass over the delay line.
// No new item is accepted until a sample is done: after the filter pass in fixed
//   mode, after the filter pass plus read-modify-write update pass in adaptive mode.
// Reset: registers return to reset values, then a clearing pass zeroes both
//   memories, during which no item is accepted.
// ----------------------------------------------------------------------------
// lms_adaptive_fir_filter
// FIR filter with optional LMS coefficient update, APB register port.
// ----------------------------------------------------------------------------
module lms_adaptive_fir_filter #(
  parameter int TAPS         = 512,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 24,
  parameter int IW           = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic signed [SAMPLE_WIDTH-1:0] primary_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] reference_sample,
  input  logic [IW-1:0]                  coef_index,
  input  logic signed [COEF_WIDTH-1:0]   coef_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] result_sample,
  output logic                           saturated,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import lmsf_pkg::*;

  cfg_t cfg;

  lmsf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lmsf_core #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH),
    .IW           (IW)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .primary_sample   (primary_sample),
    .reference_sample (reference_sample),
    .coef_index       (coef_index),
    .coef_value       (coef_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_sample    (result_sample),
    .saturated        (saturated)
  );

endmodule

// ===== hw/rtl/lmsf_cfg.sv =====
// ----------------------------------------------------------------------------
// lmsf_cfg
// APB-style register file holding the mode bit and the step size.
// ----------------------------------------------------------------------------
module lmsf_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output lmsf_pkg::cfg_t   cfg
);
  import lmsf_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adapt <= ADAPT_RESET;
      cfg.step  <= STEP_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_ADAPT: cfg.adapt <= pwdata[0];
        REG_STEP:  cfg.step  <= pwdata[MU_WIDTH-1:0];
        default:   ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[2])
      REG_ADAPT: prdata = {31'd0, cfg.adapt};
      REG_STEP:  prdata = {{(32-MU_WIDTH){1'b0}}, cfg.step};
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/lmsf_core.sv =====
// ----------------------------------------------------------------------------
// lmsf_core
// Sequencer, delay-line and coefficient memories shared by the filter pass
// and the coefficient update pass, and the separate MAC datapath of each pass.
// ----------------------------------------------------------------------------
module lmsf_core #(
  parameter int TAPS         = 512,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 24,
  parameter int IW           = 9
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lmsf_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic signed [SAMPLE_WIDTH-1:0] primary_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] reference_sample,
  input  logic [IW-1:0]                  coef_index,
  input  logic signed [COEF_WIDTH-1:0]   coef_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] result_sample,
  output logic                           saturated
);
  import lmsf_pkg::*;

  localparam int SF = SAMPLE_WIDTH - 1;
  localparam int CF = COEF_WIDTH - 2;
  localparam int US = 2 * SF + MU_FRAC - CF;
  localparam logic [IW-1:0] LAST = IW'(TAPS - 1);
  localparam logic signed [ACC_W-1:0] RES_HI = ACC_W'((64'sd1 <<< SF) - 1);
  localparam logic signed [ACC_W-1:0] RES_LO = -RES_HI - 1;
  localparam logic signed [ACC_W-1:0] CO_HI  = ACC_W'((64'sd1 <<< (COEF_WIDTH-1)) - 1);
  localparam logic signed [ACC_W-1:0] CO_LO  = -CO_HI - 1;

  state_t state;

  // Memories
  logic signed [SAMPLE_WIDTH-1:0] dmem [TAPS];
  logic signed [COEF_WIDTH-1:0]   cmem [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] d_q;
  logic signed [COEF_WIDTH-1:0]   c_q;
  logic                           d_we, c_we;
  logic [IW-1:0]                  d_waddr, c_waddr;
  logic signed [SAMPLE_WIDTH-1:0] d_wdata;
  logic signed [COEF_WIDTH-1:0]   c_wdata;

  logic [IW-1:0] cnt, ptr, rp;
  logic [IW-1:0] ptr_inc, rp_inc;
  logic          in_acc, emit_fire, issue_f, issue_u;
  logic signed [SAMPLE_WIDTH-1:0] prim, err;

  // Filter pipeline
  logic                                      s1, s2;
  logic signed [SAMPLE_WIDTH+COEF_WIDTH-1:0] fprod;
  logic signed [ACC_W-1:0]                   acc, rnd, shifted;

  // Update pipeline
  logic                           u1, u2, u3, u4;
  logic [IW-1:0]                  a1, a2, a3, a4;
  logic signed [COEF_WIDTH-1:0]   c2, c3, c4;
  logic signed [2*SAMPLE_WIDTH-1:0] p1;
  logic signed [ACC_W-1:0]        p2, delta, csum;
  logic signed [COEF_WIDTH-1:0]   c_new;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign ptr_inc   = (ptr == LAST) ? '0 : ptr + 1'b1;
  assign rp_inc    = (rp == LAST) ? '0 : rp + 1'b1;
  assign issue_f   = (state == ST_FILT);
  assign issue_u   = (state == ST_UPD);
  assign emit_fire = (state == ST_EMIT) && (!out_valid || !out_stall);

  // Memory write port selection
  always_comb begin
    d_we    = 1'b0;
    d_waddr = ptr;
    d_wdata = reference_sample;
    c_we    = 1'b0;
    c_waddr = coef_index;
    c_wdata = coef_value;
    if (state == ST_CLEAR) begin
      d_we    = 1'b1;
      d_waddr = cnt;
      d_wdata = '0;
      c_we    = 1'b1;
      c_waddr = cnt;
      c_wdata = '0;
    end else if (u4) begin
      c_we    = 1'b1;
      c_waddr = a4;
      c_wdata = c_new;
    end else if (in_acc) begin
      d_we = !op;
      c_we = op && ({1'b0, coef_index} < (IW+1)'(TAPS));
    end
  end

  // Synchronous memories, registered read
  always_ff @(posedge clk) begin
    if (d_we) dmem[d_waddr] <= d_wdata;
    d_q <= dmem[rp];
  end

  always_ff @(posedge clk) begin
    if (c_we) cmem[c_waddr] <= c_wdata;
    c_q <= cmem[cnt];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      ptr   <= '0;
      rp    <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
          if (cnt == LAST) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc && !op) begin
            ptr   <= ptr_inc;
            rp    <= ptr_inc;
            cnt   <= '0;
            state <= ST_FILT;
          end
        end
        ST_FILT: begin
          rp  <= rp_inc;
          cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
          if (cnt == LAST) begin
            rp    <= ptr;
            state <= ST_FDRAIN;
          end
        end
        ST_FDRAIN: if (!s1 && !s2) state <= ST_CALC;
        ST_CALC:   state <= ST_EMIT;
        ST_EMIT: begin
          if (emit_fire) state <= cfg.adapt ? ST_UPD : ST_IDLE;
        end
        ST_UPD: begin
          rp  <= rp_inc;
          cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
          if (cnt == LAST) state <= ST_UDRAIN;
        end
        ST_UDRAIN: if (!u1 && !u2 && !u3 && !u4) state <= ST_IDLE;
        default:   state <= ST_CLEAR;
      endcase
    end
  end

  // Capture primary sample with the item
  always_ff @(posedge clk) begin
    if (in_acc && !op) prim <= primary_sample;
  end

  // Filter MAC: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= 1'b0;
      s2 <= 1'b0;
    end else begin
      s1 <= issue_f;
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    fprod <= d_q * c_q;
    if (state == ST_IDLE) acc <= '0;
    else if (s2) acc <= acc + ACC_W'(fprod);
  end

  // Form rounded result: error in adaptive mode, sum otherwise
  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      if (cfg.adapt) rnd <= (ACC_W'(prim) <<< CF) - acc + (64'sd1 <<< (CF-1));
      else           rnd <= acc + (64'sd1 <<< (CF-1));
    end
  end

  assign shifted = rnd >>> CF;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      if (shifted > RES_HI) begin
        result_sample <= SAMPLE_WIDTH'(RES_HI);
        err           <= SAMPLE_WIDTH'(RES_HI);
        saturated     <= 1'b1;
      end else if (shifted < RES_LO) begin
        result_sample <= SAMPLE_WIDTH'(RES_LO);
        err           <= SAMPLE_WIDTH'(RES_LO);
        saturated     <= 1'b1;
      end else begin
        result_sample <= SAMPLE_WIDTH'(shifted);
        err           <= SAMPLE_WIDTH'(shifted);
        saturated     <= 1'b0;
      end
    end
  end

  // Update pipeline: err*tap, times mu, round, add and saturate, write back
  always_ff @(posedge clk) begin
    if (rst) begin
      u1 <= 1'b0;
      u2 <= 1'b0;
      u3 <= 1'b0;
      u4 <= 1'b0;
    end else begin
      u1 <= issue_u;
      u2 <= u1;
      u3 <= u2;
      u4 <= u3;
    end
  end

  always_ff @(posedge clk) begin
    a1    <= cnt;
    a2    <= a1;
    c2    <= c_q;
    p1    <= err * d_q;
    a3    <= a2;
    c3    <= c2;
    p2    <= ACC_W'(p1) * ACC_W'($signed({1'b0, cfg.step}));
    a4    <= a3;
    c4    <= c3;
    delta <= (p2 + (64'sd1 <<< (US-1))) >>> US;
  end

  assign csum  = ACC_W'(c4) + delta;
  assign c_new = (csum > CO_HI) ? COEF_WIDTH'(CO_HI) :
                 (csum < CO_LO) ? COEF_WIDTH'(CO_LO) : COEF_WIDTH'(csum);

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst) !(s2 && u1))
    else $error("filter and update passes overlap");
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!s1 && !u1 && !out_valid))
    else $error("activity during clearing pass");
  a_emit_upd: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && cfg.adapt) |=> (state == ST_UPD))
    else $error("update pass did not follow adaptive result");
  a_wb_busy: assert property (@(posedge clk) disable iff (rst)
    u4 |-> (state == ST_UPD || state == ST_UDRAIN))
    else $error("coefficient write-back outside update pass");

endmodule
